@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/mcrm_pkg.sv @@
// Constants, types and grid functions for the marker code rotation match.
// No dependencies.
package mcrm_pkg;

	localparam int GRID_SIDE = 4;
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int FIELD_W   = 16;
	localparam int NUM_ROT   = 4;
	localparam int ROT_W     = 2;
	localparam int CNT_W     = $clog2(GRID_SIDE + 1);
	localparam int SCORE_W   = $clog2(CELLS + 1);
	localparam int DIST_W    = 5;
	localparam int DIST_MAX  = 31;
	localparam int OUT_W     = ((DIST_W + ROT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_W - DIST_W - ROT_W;
	localparam logic [FIELD_W-1:0] TEMPLATE_RST = 16'hF9BF;

	typedef logic [CELLS-1:0] grid_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [NUM_ROT-1:0][1:0][GRID_SIDE-1:0][GRID_SIDE-1:0][CNT_W-1:0] mis_t;
	typedef logic [NUM_ROT-1:0][1:0][GRID_SIDE-1:0][CNT_W-1:0] best_t;
	typedef logic [NUM_ROT-1:0][SCORE_W-1:0] dist_t;

	function automatic grid_t to_grid(logic [FIELD_W-1:0] f);
		grid_t g;
		g = '0;
		for (int i = 0; i < CELLS; i++) begin
			if (i < FIELD_W) begin
				g[i] = f[i];
			end
		end
		return g;
	endfunction

	function automatic grid_t rot_ccw(grid_t g);
		grid_t r;
		r = '0;
		for (int i = 0; i < GRID_SIDE; i++) begin
			for (int j = 0; j < GRID_SIDE; j++) begin
				r[i*GRID_SIDE + j] = g[(GRID_SIDE-1-j)*GRID_SIDE + i];
			end
		end
		return r;
	endfunction

	function automatic cnt_t mis_count(grid_t a, grid_t b, logic tr, int y, int p);
		cnt_t s;
		logic av;
		logic bv;
		s = '0;
		for (int x = 0; x < GRID_SIDE; x++) begin
			av = tr ? a[x*GRID_SIDE + y] : a[y*GRID_SIDE + x];
			bv = tr ? b[x*GRID_SIDE + p] : b[p*GRID_SIDE + x];
			s = s + cnt_t'(av ^ bv);
		end
		return s;
	endfunction

	function automatic logic [DIST_W-1:0] sat_dist(score_t v);
		logic [DIST_W-1:0] r;
		if (32'(v) > DIST_MAX) begin
			r = DIST_W'(DIST_MAX);
		end else begin
			r = DIST_W'(v);
		end
		return r;
	endfunction

endpackage

@@ rtl/mcrm_mismatch.sv @@
// Stage 1: rotates the grid four ways and counts mismatches of every line pair.
// Depends on mcrm_pkg.
module mcrm_mismatch import mcrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FIELD_W-1:0] grid,
	input  logic [FIELD_W-1:0] template_code,
	output logic               out_valid,
	input  logic               out_ready,
	output mis_t               mis
);

	logic  v_s1;
	mis_t  mis_s1;
	mis_t  mis_c;
	grid_t rot_g [NUM_ROT];
	grid_t tmpl_g;

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign mis       = mis_s1;

	always_comb begin
		tmpl_g   = to_grid(template_code);
		rot_g[0] = to_grid(grid);
		for (int k = 1; k < NUM_ROT; k++) begin
			rot_g[k] = rot_ccw(rot_g[k-1]);
		end
		for (int k = 0; k < NUM_ROT; k++) begin
			for (int t = 0; t < 2; t++) begin
				for (int y = 0; y < GRID_SIDE; y++) begin
					for (int p = 0; p < GRID_SIDE; p++) begin
						mis_c[k][t][y][p] = mis_count(rot_g[k], tmpl_g, t[0], y, p);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mis_s1 <= mis_c;
		end
	end

endmodule

@@ rtl/mcrm_reduce.sv @@
// Stages 2 and 3: least mismatch per line, then line sums and row/column maximum.
// Depends on mcrm_pkg.
module mcrm_reduce import mcrm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  mis_t  mis,
	output logic  out_valid,
	input  logic  out_ready,
	output dist_t rot_dist
);

	logic   v_s2;
	logic   v_s3;
	logic   rdy_s3;
	best_t  best_s2;
	best_t  best_c;
	dist_t  dist_s3;
	dist_t  dist_c;
	score_t sum_c [2];

	assign rdy_s3    = !v_s3 || out_ready;
	assign in_ready  = !v_s2 || rdy_s3;
	assign out_valid = v_s3;
	assign rot_dist  = dist_s3;

	always_comb begin
		for (int k = 0; k < NUM_ROT; k++) begin
			for (int t = 0; t < 2; t++) begin
				for (int y = 0; y < GRID_SIDE; y++) begin
					best_c[k][t][y] = mis[k][t][y][0];
					for (int p = 1; p < GRID_SIDE; p++) begin
						if (mis[k][t][y][p] < best_c[k][t][y]) begin
							best_c[k][t][y] = mis[k][t][y][p];
						end
					end
				end
			end
		end
	end

	always_comb begin
		dist_c = '0;
		sum_c[0] = '0;
		sum_c[1] = '0;
		for (int k = 0; k < NUM_ROT; k++) begin
			for (int t = 0; t < 2; t++) begin
				sum_c[t] = '0;
				for (int y = 0; y < GRID_SIDE; y++) begin
					sum_c[t] = sum_c[t] + score_t'(best_s2[k][t][y]);
				end
			end
			dist_c[k] = (sum_c[0] > sum_c[1]) ? sum_c[0] : sum_c[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			best_s2 <= best_c;
		end
		if (rdy_s3 && v_s2) begin
			dist_s3 <= dist_c;
		end
	end

endmodule

@@ rtl/mcrm_select.sv @@
// Stage 4: picks the smallest rotation distance, earliest on tie, into the output register.
// Depends on mcrm_pkg.
module mcrm_select import mcrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dist_t             rot_dist,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DIST_W-1:0] min_distance,
	output logic [ROT_W-1:0]  best_rotation
);

	logic              v_s4;
	logic [DIST_W-1:0] dist_s4;
	logic [ROT_W-1:0]  rot_s4;
	score_t            best_c;
	logic [ROT_W-1:0]  rot_c;

	assign in_ready      = !v_s4 || out_ready;
	assign out_valid     = v_s4;
	assign min_distance  = dist_s4;
	assign best_rotation = rot_s4;

	always_comb begin
		best_c = rot_dist[0];
		rot_c  = '0;
		for (int k = 1; k < NUM_ROT; k++) begin
			if (rot_dist[k] < best_c) begin
				best_c = rot_dist[k];
				rot_c  = ROT_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dist_s4 <= sat_dist(best_c);
			rot_s4  <= rot_c;
		end
	end

endmodule

@@ rtl/marker_code_rotation_match.sv @@
// Top level of the marker code rotation match: template register and four-stage pipeline.
// Depends on mcrm_pkg, mcrm_mismatch, mcrm_reduce and mcrm_select.
//
// Scores each sampled 4x4 grid against the template grid under four anticlockwise quarter
// turns and returns the smallest distance and the first turn count that reaches it. One item
// is taken every cycle unless back-pressure fills the pipeline; each item passes through the
// four register stages (line mismatch counts, least count per line, line sums with the
// row/column maximum, rotation select into the output register). Each stage holds while
// the next one is full and stalled, so bubbles close up and nothing is dropped. The template
// resets to 0xF9BF and must be written only while the block is idle; the block does not enforce it.
module marker_code_rotation_match import mcrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [FIELD_W-1:0] s_tdata,   // grid_bits[15:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // min_distance[4:0], best_rotation[6:5], zero[7]
	input  logic               cfg_wen,
	input  logic [FIELD_W-1:0] cfg_wdata  // template_code[15:0]
);

	logic [FIELD_W-1:0] template_q;
	logic               v1;
	logic               r2;
	logic               v3;
	logic               r4;
	mis_t               mis;
	dist_t              rot_dist;
	logic [DIST_W-1:0]  min_distance;
	logic [ROT_W-1:0]   best_rotation;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			template_q <= TEMPLATE_RST;
		end else if (cfg_wen) begin
			template_q <= cfg_wdata;
		end
	end

	mcrm_mismatch u_mismatch (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.grid          (s_tdata),
		.template_code (template_q),
		.out_valid     (v1),
		.out_ready     (r2),
		.mis           (mis)
	);

	mcrm_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2),
		.mis       (mis),
		.out_valid (v3),
		.out_ready (r4),
		.rot_dist  (rot_dist)
	);

	mcrm_select u_select (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v3),
		.in_ready      (r4),
		.rot_dist      (rot_dist),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.min_distance  (min_distance),
		.best_rotation (best_rotation)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, best_rotation, min_distance};

endmodule

@@ rtl/mcrm_checker.sv @@
// Port-level checks for the marker code rotation match, bound to the top level.
// Depends on mcrm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcrm_checker import mcrm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`CHK_IMPLY(a_dist_range, clk, arst_n, m_tvalid, 32'(m_tdata[DIST_W-1:0]) <= CELLS)
	`CHK_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[OUT_W-1] == 1'b0)
	`CHK_IMPLY(a_stall_only_full, clk, arst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind marker_code_rotation_match mcrm_checker u_mcrm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/marker_code_rotation_match_test.sv @@
// Self-checking testbench for marker_code_rotation_match: directed table, then random grids
// under several templates, with bursty input and stalling output, scored by a local model.
// Depends on mcrm_pkg and marker_code_rotation_match.
module marker_code_rotation_match_test;
	import mcrm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DIST_W-1:0] d_min;
		logic [ROT_W-1:0]  rot;
	} match_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_SCORED, ROW_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [FIELD_W-1:0] value;
		logic [DIST_W-1:0] d_min;
		logic [ROT_W-1:0]  rot;
	} stim_row_t;

	localparam int NUM_ROWS = 25;
	localparam int EXP_DEPTH = 1024;
	localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
		'{ROW_TYPED,  16'hF9BF, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h0000, 5'd0,  2'd0},
		'{ROW_SCORED, 16'hFFFF, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h0001, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h8000, 5'd0,  2'd0},
		'{ROW_SCORED, 16'hAAAA, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h5555, 5'd0,  2'd0},
		'{ROW_WRITE,  16'h0000, 5'd0,  2'd0},
		'{ROW_TYPED,  16'h0000, 5'd0,  2'd0},
		'{ROW_TYPED,  16'hFFFF, 5'd16, 2'd0},
		'{ROW_SCORED, 16'h0F0F, 5'd0,  2'd0},
		'{ROW_WRITE,  16'hFFFF, 5'd0,  2'd0},
		'{ROW_TYPED,  16'h0000, 5'd16, 2'd0},
		'{ROW_TYPED,  16'hFFFF, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h7FFF, 5'd0,  2'd0},
		'{ROW_WRITE,  16'h1111, 5'd0,  2'd0},
		'{ROW_TYPED,  16'h1111, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h000F, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h8888, 5'd0,  2'd0},
		'{ROW_SCORED, 16'hF000, 5'd0,  2'd0},
		'{ROW_WRITE,  16'h8421, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h1248, 5'd0,  2'd0},
		'{ROW_TYPED,  16'h8421, 5'd0,  2'd0},
		'{ROW_SCORED, 16'h4B2D, 5'd0,  2'd0},
		'{ROW_SCORED, 16'hD2B4, 5'd0,  2'd0}
	};

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [FIELD_W-1:0] s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;
	logic               cfg_wen;
	logic [FIELD_W-1:0] cfg_wdata;

	logic [FIELD_W-1:0] template_now;
	match_t             exp_mem [EXP_DEPTH];
	int                 exp_wr = 0;
	int                 exp_rd = 0;
	int                 fail_count;
	int                 burst_left;

	marker_code_rotation_match DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	function automatic logic [FIELD_W-1:0] quarter_turn(logic [FIELD_W-1:0] g);
		logic [FIELD_W-1:0] r;
		r = '0;
		for (int i = 0; i < GRID_SIDE; i++) begin
			for (int j = 0; j < GRID_SIDE; j++) begin
				r[i*GRID_SIDE + j] = g[(GRID_SIDE-1-j)*GRID_SIDE + i];
			end
		end
		return r;
	endfunction

	function automatic int line_sum(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b, bit by_col);
		int total;
		int least;
		int s;
		logic av;
		logic bv;
		total = 0;
		for (int y = 0; y < GRID_SIDE; y++) begin
			least = GRID_SIDE + 1;
			for (int p = 0; p < GRID_SIDE; p++) begin
				s = 0;
				for (int x = 0; x < GRID_SIDE; x++) begin
					av = by_col ? a[x*GRID_SIDE + y] : a[y*GRID_SIDE + x];
					bv = by_col ? b[x*GRID_SIDE + p] : b[p*GRID_SIDE + x];
					s += int'(av ^ bv);
				end
				if (s < least) begin
					least = s;
				end
			end
			total += least;
		end
		return total;
	endfunction

	function automatic match_t score_grid(logic [FIELD_W-1:0] g, logic [FIELD_W-1:0] tpl);
		match_t m;
		int best;
		int d;
		int rs;
		int cs;
		logic [FIELD_W-1:0] cur;
		best = 0;
		m.rot = '0;
		cur = g;
		for (int k = 0; k < NUM_ROT; k++) begin
			rs = line_sum(cur, tpl, 1'b0);
			cs = line_sum(cur, tpl, 1'b1);
			d = (rs > cs) ? rs : cs;
			if (k == 0 || d < best) begin
				best = d;
				m.rot = ROT_W'(k);
			end
			cur = quarter_turn(cur);
		end
		if (best > DIST_MAX) begin
			best = DIST_MAX;
		end
		m.d_min = DIST_W'(best);
		return m;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("marker_code_rotation_match_test NOT OK");
		$finish;
	end

	// receiver: ready pattern is redrawn at random from four modes
	int unsigned ready_mode;
	int unsigned ready_cnt;
	initial begin
		m_tready = 1'b0;
		ready_mode = 0;
		ready_cnt = 0;
		forever begin
			@(negedge clk);
			if (ready_cnt % 64 == 0) begin
				ready_mode = $urandom_range(0, 3);
			end
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (ready_cnt % 4 == 0);
				default: m_tready <= (ready_cnt % 16 >= 8);
			endcase
			ready_cnt++;
		end
	end

	always @(posedge clk) begin
		match_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected result min_distance %0d best_rotation %0d",
					$time, m_tdata[4:0], m_tdata[6:5]);
				fail_count++;
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (m_tdata[4:0] !== want.d_min) begin
					$display("%0t: min_distance expected %0d got %0d",
						$time, want.d_min, m_tdata[4:0]);
					fail_count++;
				end
				if (m_tdata[6:5] !== want.rot) begin
					$display("%0t: best_rotation expected %0d got %0d",
						$time, want.rot, m_tdata[6:5]);
					fail_count++;
				end
			end
		end
	end

	task automatic send_grid(logic [FIELD_W-1:0] g, bit typed, match_t typed_score);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= g;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		exp_mem[exp_wr % EXP_DEPTH] = typed ? typed_score : score_grid(g, template_now);
		exp_wr++;
	endtask

	task automatic idle_cycles(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			idle_cycles($urandom_range(1, 6));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic drain();
		idle_cycles(1);
		while (exp_wr != exp_rd) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_template(logic [FIELD_W-1:0] v);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		template_now = v;
	endtask

	initial begin
		logic [FIELD_W-1:0] phase_tpl [6];
		logic [FIELD_W-1:0] g;
		int pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		fail_count = 0;
		burst_left = 0;
		template_now = TEMPLATE_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_WRITE) begin
				write_template(DIR_ROWS[i].value);
			end else begin
				pace();
				send_grid(DIR_ROWS[i].value, DIR_ROWS[i].kind == ROW_TYPED,
					'{DIR_ROWS[i].d_min, DIR_ROWS[i].rot});
			end
		end

		phase_tpl[0] = 16'h0000;
		phase_tpl[1] = 16'($urandom);
		phase_tpl[2] = 16'hFFFF;
		phase_tpl[3] = 16'($urandom);
		phase_tpl[4] = 16'($urandom);
		phase_tpl[5] = TEMPLATE_RST;
		foreach (phase_tpl[t]) begin
			write_template(phase_tpl[t]);
			repeat (80) begin
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					// rotated template with up to three cells flipped
					g = template_now;
					repeat ($urandom_range(0, 3)) g = quarter_turn(g);
					repeat ($urandom_range(0, 3)) g[$urandom_range(0, FIELD_W-1)] ^= 1'b1;
				end else if (pick == 4) begin
					g = 16'(1) << $urandom_range(0, FIELD_W-1);
					if ($urandom_range(0, 1)) g = ~g;
				end else begin
					g = 16'($urandom);
				end
				pace();
				send_grid(g, 1'b0, '0);
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("marker_code_rotation_match_test OK");
		end else begin
			$display("marker_code_rotation_match_test NOT OK");
		end
		$finish;
	end

endmodule

@@ marker_code_rotation_match.f @@
+incdir+rtl
rtl/mcrm_pkg.sv
rtl/mcrm_mismatch.sv
rtl/mcrm_reduce.sv
rtl/mcrm_select.sv
rtl/marker_code_rotation_match.sv
rtl/mcrm_checker.sv
tb/marker_code_rotation_match_test.sv
